// ===== design/json_string_unescape_utf8_defines.svh =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8 assertion macros
// Shared concurrent checks, clocked on clk and disabled during rst.
// ----------------------------------------------------------------------------
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu: same-cycle check failed");

// next-cycle implication
`define JSU_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu: next-cycle check failed");

`endif

// ===== design/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Codes, character constants and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [3:0] ERR_NONE         = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE     = 4'd1;
  localparam logic [3:0] ERR_CTRL_CHAR    = 4'd2;
  localparam logic [3:0] ERR_EOF_ESC      = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC      = 4'd4;
  localparam logic [3:0] ERR_BAD_HEX      = 4'd5;
  localparam logic [3:0] ERR_EOF_HEX      = 4'd6;
  localparam logic [3:0] ERR_MISSING_LOW  = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW      = 4'd8;
  localparam logic [3:0] ERR_UNEXP_LOW    = 4'd9;
  localparam logic [3:0] ERR_UNTERMINATED = 4'd10;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5c;
  localparam logic [7:0] CH_SLASH  = 8'h2f;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6e;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hd800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hdbff;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hdc00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hdfff;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  localparam logic [7:0] UTF8_LEAD2 = 8'hc0;
  localparam logic [7:0] UTF8_LEAD3 = 8'he0;
  localparam logic [7:0] UTF8_LEAD4 = 8'hf0;
  localparam logic [7:0] UTF8_CONT  = 8'h80;

  typedef logic [3:0][7:0] bytes_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] digit;
  } hex_t;

  typedef struct packed {
    logic [2:0] len;
    bytes_t     bytes;
  } utf8_t;

  function automatic hex_t hex_value(input logic [7:0] c);
    hex_t r;
    r.ok    = 1'b1;
    r.digit = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.digit = 4'(c - 8'h30);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r.digit = 4'(c - 8'h57);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.digit = 4'(c - 8'h37);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  // bytes[0] leaves first
  function automatic utf8_t utf8_encode(input logic [20:0] cp);
    utf8_t r;
    r.bytes = '0;
    if (cp <= 21'h7f) begin
      r.len      = 3'd1;
      r.bytes[0] = {1'b0, cp[6:0]};
    end else if (cp <= 21'h7ff) begin
      r.len      = 3'd2;
      r.bytes[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[5:0]};
    end else if (cp <= 21'hffff) begin
      r.len      = 3'd3;
      r.bytes[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[5:0]};
    end else begin
      r.len      = 3'd4;
      r.bytes[0] = UTF8_LEAD4 | {5'b00000, cp[20:18]};
      r.bytes[1] = UTF8_CONT | {2'b00, cp[17:12]};
      r.bytes[2] = UTF8_CONT | {2'b00, cp[11:6]};
      r.bytes[3] = UTF8_CONT | {2'b00, cp[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== design/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Unescapes one quoted JSON string, byte by byte, into UTF-8 words.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one source byte per word, or end_of_input
// set to mark the end of the text. Output channel (out_valid/out_ready): one
// result word each, kind = data byte, string closed or error, with last on
// the final word caused by an input word.
// Each accepted word is parsed in the cycle it is taken; its results sit in a
// four-entry output shift register from the next cycle on.
// Throughput: one input word per cycle while each word gives at most one
// result and the receiver takes each one. A code point that encodes to more than
// one UTF-8 byte holds the input while the shift register drains; in_ready goes
// high again in the cycle the last pending result is being taken.
// When the receiver stalls, the current result holds and input is accepted
// only if no result is pending.
// Reset (rst, synchronous): parser back to idle awaiting the opening quote,
// surrogate and hex state cleared, pending results dropped.
// After an error or the closing quote the parser returns to idle.
// ----------------------------------------------------------------------------
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       end_of_input,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [1:0] kind,
  output logic [3:0] error_code,
  output logic       last
);

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'd0,
    MODE_STR    = 4'd1,
    MODE_ESC    = 4'd2,
    MODE_HEX    = 4'd3,
    MODE_HEXBAD = 4'd4,
    MODE_NEEDBS = 4'd5,
    MODE_NEEDU  = 4'd6,
    MODE_LOW    = 4'd7,
    MODE_LOWBAD = 4'd8
  } mode_t;

  mode_t       mode, mode_next;
  logic [15:0] acc, acc_next;
  logic [1:0]  cnt, cnt_next;
  logic [9:0]  hs, hs_next;

  bytes_t      res_bytes;
  logic [2:0]  res_cnt;
  logic [1:0]  res_kind;
  logic [3:0]  res_err;

  logic        accept, pop;

  // step results
  logic [2:0]  st_n;
  bytes_t      st_bytes;
  logic [1:0]  st_kind;
  logic [3:0]  st_err;
  logic        fail;
  logic [3:0]  fail_code;
  logic        emit;
  logic [20:0] cp;
  logic        low;
  hex_t        hv;
  logic [15:0] v_new;
  utf8_t       enc;

  assign out_valid  = (res_cnt != 3'd0);
  assign out_byte   = res_bytes[0];
  assign kind       = res_kind;
  assign error_code = res_err;
  assign last       = (res_cnt == 3'd1);

  assign pop      = out_valid && out_ready;
  // take a word only if the result buffer is empty by the next edge
  assign in_ready = (res_cnt == 3'd0) || (res_cnt == 3'd1 && out_ready);
  assign accept   = in_valid && in_ready;

  assign hv    = hex_value(in_byte);
  assign v_new = {acc[11:0], hv.digit};
  assign low   = (mode == MODE_LOW);
  assign enc   = utf8_encode(cp);

  always_comb begin
    mode_next = mode;
    acc_next  = acc;
    cnt_next  = cnt;
    hs_next   = hs;
    st_n      = 3'd0;
    st_bytes  = '0;
    st_kind   = KIND_DATA;
    st_err    = ERR_NONE;
    fail      = 1'b0;
    fail_code = ERR_NONE;
    emit      = 1'b0;
    cp        = '0;
    case (mode)
      MODE_STR: begin
        if (end_of_input) begin
          fail      = 1'b1;
          fail_code = ERR_UNTERMINATED;
        end else if (in_byte == CH_QUOTE) begin
          mode_next = MODE_IDLE;
          acc_next  = '0;
          cnt_next  = '0;
          hs_next   = '0;
          st_n      = 3'd1;
          st_kind   = KIND_CLOSE;
        end else if (in_byte < CTRL_LIMIT) begin
          fail      = 1'b1;
          fail_code = ERR_CTRL_CHAR;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          st_n        = 3'd1;
          st_bytes[0] = in_byte;
        end
      end
      MODE_ESC: begin
        if (end_of_input) begin
          fail      = 1'b1;
          fail_code = ERR_EOF_ESC;
        end else begin
          mode_next = MODE_STR;
          st_n      = 3'd1;
          case (in_byte)
            CH_QUOTE, CH_BSLASH, CH_SLASH: st_bytes[0] = in_byte;
            CH_B: st_bytes[0] = 8'h08;
            CH_F: st_bytes[0] = 8'h0c;
            CH_N: st_bytes[0] = 8'h0a;
            CH_R: st_bytes[0] = 8'h0d;
            CH_T: st_bytes[0] = 8'h09;
            CH_U: begin
              mode_next = MODE_HEX;
              acc_next  = '0;
              cnt_next  = '0;
              st_n      = 3'd0;
            end
            default: begin
              fail      = 1'b1;
              fail_code = ERR_BAD_ESC;
            end
          endcase
        end
      end
      MODE_HEX, MODE_LOW: begin
        if (end_of_input) begin
          fail      = 1'b1;
          fail_code = ERR_EOF_HEX;
        end else if (!hv.ok) begin
          if (cnt == 2'd3) begin
            fail      = 1'b1;
            fail_code = ERR_BAD_HEX;
          end else begin
            cnt_next  = cnt + 2'd1;
            mode_next = low ? MODE_LOWBAD : MODE_HEXBAD;
          end
        end else if (cnt == 2'd3) begin
          // fourth digit completes the group
          acc_next = '0;
          cnt_next = '0;
          if (low) begin
            if (v_new < LOW_SURR_MIN || v_new > LOW_SURR_MAX) begin
              fail      = 1'b1;
              fail_code = ERR_BAD_LOW;
            end else begin
              mode_next = MODE_STR;
              emit      = 1'b1;
              cp        = SUPP_BASE + {1'b0, hs, v_new[9:0]};
            end
          end else if (v_new >= HIGH_SURR_MIN && v_new <= HIGH_SURR_MAX) begin
            hs_next   = v_new[9:0];
            mode_next = MODE_NEEDBS;
          end else if (v_new >= LOW_SURR_MIN && v_new <= LOW_SURR_MAX) begin
            fail      = 1'b1;
            fail_code = ERR_UNEXP_LOW;
          end else begin
            mode_next = MODE_STR;
            emit      = 1'b1;
            cp        = {5'b00000, v_new};
          end
        end else begin
          acc_next = v_new;
          cnt_next = cnt + 2'd1;
        end
      end
      MODE_HEXBAD, MODE_LOWBAD: begin
        if (end_of_input) begin
          fail      = 1'b1;
          fail_code = ERR_EOF_HEX;
        end else if (cnt == 2'd3) begin
          fail      = 1'b1;
          fail_code = ERR_BAD_HEX;
        end else begin
          cnt_next = cnt + 2'd1;
        end
      end
      MODE_NEEDBS: begin
        if (end_of_input || in_byte != CH_BSLASH) begin
          fail      = 1'b1;
          fail_code = ERR_MISSING_LOW;
        end else begin
          mode_next = MODE_NEEDU;
        end
      end
      MODE_NEEDU: begin
        if (end_of_input || in_byte != CH_U) begin
          fail      = 1'b1;
          fail_code = ERR_MISSING_LOW;
        end else begin
          mode_next = MODE_LOW;
          acc_next  = '0;
          cnt_next  = '0;
        end
      end
      default: begin
        // idle and unused codes: wait for the opening quote
        if (end_of_input || in_byte != CH_QUOTE) begin
          fail      = 1'b1;
          fail_code = ERR_NO_QUOTE;
        end else begin
          mode_next = MODE_STR;
          acc_next  = '0;
          cnt_next  = '0;
          hs_next   = '0;
        end
      end
    endcase
    if (emit) begin
      st_n     = enc.len;
      st_bytes = enc.bytes;
    end
    if (fail) begin
      mode_next = MODE_IDLE;
      acc_next  = '0;
      cnt_next  = '0;
      hs_next   = '0;
      st_n      = 3'd1;
      st_bytes  = '0;
      st_kind   = KIND_ERROR;
      st_err    = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      acc     <= '0;
      cnt     <= '0;
      hs      <= '0;
      res_cnt <= '0;
    end else begin
      if (accept) begin
        mode      <= mode_next;
        acc       <= acc_next;
        cnt       <= cnt_next;
        hs        <= hs_next;
        res_cnt   <= st_n;
        res_bytes <= st_bytes;
        res_kind  <= st_kind;
        res_err   <= st_err;
      end else if (pop) begin
        res_cnt   <= res_cnt - 3'd1;
        res_bytes <= {8'h00, res_bytes[3:1]};
      end
    end
  end

  `JSU_ASSERT_IMPL(a_multi_blocks_input, res_cnt > 3'd1, !in_ready)
  `JSU_ASSERT_IMPL(a_buffer_bound, 1'b1, res_cnt <= 3'd4)
  `JSU_ASSERT_IMPL(a_nondata_is_last, out_valid && kind != KIND_DATA, last && res_cnt == 3'd1)
  `JSU_ASSERT_IMPL(a_err_code_match, out_valid, (kind == KIND_ERROR) != (error_code == ERR_NONE))
  `JSU_ASSERT_NEXT(a_drain_empty, pop && last && !accept, !out_valid)

endmodule
